FILE: rtl/core/ird_pkg.sv
// Shared types and constants for the IR remote pulse decoder.
// No dependencies; used by ird_classify and ir_remote_pulse_decoder.
package ird_pkg;

  localparam int IRD_WORD_BITS = 32;
  localparam int IRD_TIME_BITS = 16;

  localparam int REG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int STATUS_BITS    = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_START     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ONE       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END       = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE = 3'd5;

  localparam logic [STATUS_BITS-1:0] STATUS_NEW    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FAIL   = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_REPEAT = 2'd2;

  typedef struct packed {
    logic [REG_BITS-1:0] start_length;
    logic [REG_BITS-1:0] one_length;
    logic [REG_BITS-1:0] zero_length;
    logic [REG_BITS-1:0] end_length;
    logic [REG_BITS-1:0] repeat_length;
    logic [REG_BITS-1:0] tolerance;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    start_length:  16'd90,
    one_length:    16'd17,
    zero_length:   16'd6,
    end_length:    16'd400,
    repeat_length: 16'd23,
    tolerance:     16'd3
  };

  // pulse class after priority resolution, at most one bit set
  typedef struct packed {
    logic start;
    logic one;
    logic zero;
    logic frame_end;
    logic rpt;
  } pulse_class_t;

endpackage

FILE: rtl/core/ird_classify.sv
// Pulse length classifier: strict window compares against the nominal lengths.
// Depends on ird_pkg (cfg_t, pulse_class_t).
module ird_classify import ird_pkg::*; #(
  parameter int TIME_BITS = IRD_TIME_BITS
) (
  input  logic [TIME_BITS-1:0] len,
  input  cfg_t                 cfg,
  output pulse_class_t         cls
);

  localparam int CMP_BITS = ((TIME_BITS > REG_BITS + 1) ? TIME_BITS : REG_BITS + 1) + 1;

  logic signed [CMP_BITS-1:0] len_s;
  logic win_start, win_one, win_zero, win_end, win_rpt;

  function automatic logic in_win(input logic signed [CMP_BITS-1:0] l,
                                  input logic [REG_BITS-1:0] nom,
                                  input logic [REG_BITS-1:0] tol);
    logic signed [CMP_BITS-1:0] lo;
    logic signed [CMP_BITS-1:0] hi;
    lo = $signed(CMP_BITS'(nom)) - $signed(CMP_BITS'(tol));
    hi = $signed(CMP_BITS'(nom)) + $signed(CMP_BITS'(tol));
    return (l > lo) && (l < hi);
  endfunction

  assign len_s     = $signed(CMP_BITS'(len));
  assign win_start = in_win(len_s, cfg.start_length, cfg.tolerance);
  assign win_one   = in_win(len_s, cfg.one_length, cfg.tolerance);
  assign win_zero  = in_win(len_s, cfg.zero_length, cfg.tolerance);
  assign win_end   = in_win(len_s, cfg.end_length, cfg.tolerance);
  assign win_rpt   = in_win(len_s, cfg.repeat_length, cfg.tolerance);

  always_comb begin
    cls = '0;
    priority if (win_start) begin
      cls.start = 1'b1;
    end else if (win_one) begin
      cls.one = 1'b1;
    end else if (win_zero) begin
      cls.zero = 1'b1;
    end else if (win_end) begin
      cls.frame_end = 1'b1;
    end else if (win_rpt) begin
      cls.rpt = 1'b1;
    end else begin
      cls = '0;
    end
  end

endmodule

FILE: rtl/core/ir_remote_pulse_decoder.sv
// Top level of the IR remote pulse decoder: edge pairing, bit assembly, results.
// Depends on ird_pkg and ird_classify.
//
//   channel   signals                                   direction
//   ------    ---------------------------------------   ---------
//   config    write_enable, write_index, write_data     in
//   edge      edge_valid/edge_ready, edge_time          in
//   result    result_valid/result_ready, command_word,  out
//             status
//
// One edge request per cycle while no held result blocks it: input register, classify and update, result register.
// Result valid is registered once the edge that ends the pulse advances out of the input register.
// A held result blocks only an edge that produces a result; other edges still pass.
// Synchronous reset restores register defaults and clears all decoder state.
module ir_remote_pulse_decoder import ird_pkg::*; #(
  parameter int WORD_BITS = IRD_WORD_BITS,
  parameter int TIME_BITS = IRD_TIME_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      write_enable,
  input  logic [CFG_INDEX_BITS-1:0] write_index,
  input  logic [REG_BITS-1:0]       write_data,
  input  logic                      edge_valid,
  output logic                      edge_ready,
  input  logic [TIME_BITS-1:0]      edge_time,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [WORD_BITS-1:0]      command_word,
  output logic [STATUS_BITS-1:0]    status
);

  localparam int POS_BITS = $clog2(WORD_BITS + 2) + 1;
  localparam int IDX_BITS = $clog2(WORD_BITS);
  localparam logic signed [POS_BITS-1:0] POS_RESET = '1;
  localparam logic signed [POS_BITS-1:0] POS_FULL  = POS_BITS'(WORD_BITS);
  localparam logic signed [POS_BITS-1:0] POS_SAT   = POS_BITS'(WORD_BITS + 1);
  localparam logic signed [POS_BITS-1:0] POS_MSB   = POS_BITS'(WORD_BITS - 1);
  localparam logic signed [POS_BITS-1:0] POS_ONE   = POS_BITS'(1);

  cfg_t cfg;

  logic                 s1_valid;
  logic [TIME_BITS-1:0] s1_time;

  logic [TIME_BITS-1:0]       previous_edge, previous_edge_next;
  logic                       second_edge_due, second_edge_due_next;
  logic signed [POS_BITS-1:0] bit_position, bit_position_next;
  logic                       start_seen, start_seen_next;
  logic [WORD_BITS-1:0]       shift_word, shift_word_next;
  logic [WORD_BITS-1:0]       last_good, last_good_next;

  logic [TIME_BITS-1:0]       len;
  pulse_class_t               cls;
  logic signed [POS_BITS-1:0] pos_rev;
  logic                       emit;
  logic [WORD_BITS-1:0]       emit_word;
  logic [STATUS_BITS-1:0]     emit_status;
  logic                       advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        REG_START:     cfg.start_length  <= write_data;
        REG_ONE:       cfg.one_length    <= write_data;
        REG_ZERO:      cfg.zero_length   <= write_data;
        REG_END:       cfg.end_length    <= write_data;
        REG_REPEAT:    cfg.repeat_length <= write_data;
        REG_TOLERANCE: cfg.tolerance     <= write_data;
        default: ;
      endcase
    end
  end

  assign len = s1_time - previous_edge;

  ird_classify #(
    .TIME_BITS(TIME_BITS)
  ) u_classify (
    .len(len),
    .cfg(cfg),
    .cls(cls)
  );

  assign pos_rev = POS_MSB - bit_position;

  always_comb begin
    previous_edge_next   = previous_edge;
    second_edge_due_next = second_edge_due;
    bit_position_next    = bit_position;
    start_seen_next      = start_seen;
    shift_word_next      = shift_word;
    last_good_next       = last_good;
    emit                 = 1'b0;
    emit_word            = '0;
    emit_status          = STATUS_NEW;
    if (s1_valid) begin
      previous_edge_next = s1_time;
      if (!second_edge_due) begin
        second_edge_due_next = 1'b1;
      end else begin
        second_edge_due_next = 1'b0;
        priority if (cls.start) begin
          bit_position_next = '0;
          start_seen_next   = 1'b1;
        end else if (cls.one || cls.zero) begin
          if (bit_position >= 0 && bit_position < POS_FULL) begin
            shift_word_next[pos_rev[IDX_BITS-1:0]] = cls.one;
          end
          if (bit_position < POS_SAT) begin
            bit_position_next = bit_position + POS_ONE;
          end
        end else if (cls.frame_end) begin
          emit = 1'b1;
          if (start_seen && bit_position == POS_FULL) begin
            last_good_next = shift_word;
            emit_word      = shift_word;
            emit_status    = STATUS_NEW;
          end else begin
            emit_word   = '0;
            emit_status = STATUS_FAIL;
          end
          start_seen_next   = 1'b0;
          bit_position_next = POS_RESET;
        end else if (cls.rpt) begin
          emit        = 1'b1;
          emit_word   = last_good;
          emit_status = STATUS_REPEAT;
        end else begin
          emit = 1'b0;
        end
      end
    end
  end

  assign advance    = s1_valid && (!emit || !result_valid || result_ready);
  assign edge_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (edge_valid && edge_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (edge_valid && edge_ready) begin
      s1_time <= edge_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_edge   <= '0;
      second_edge_due <= 1'b0;
      bit_position    <= POS_RESET;
      start_seen      <= 1'b0;
      shift_word      <= '0;
      last_good       <= '0;
    end else if (advance) begin
      previous_edge   <= previous_edge_next;
      second_edge_due <= second_edge_due_next;
      bit_position    <= bit_position_next;
      start_seen      <= start_seen_next;
      shift_word      <= shift_word_next;
      last_good       <= last_good_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      command_word <= emit_word;
      status       <= emit_status;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == STATUS_FAIL |-> command_word == '0)
    else $error("failed frame carries nonzero word");

  a_new_is_last_good: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == STATUS_NEW |-> command_word == last_good)
    else $error("new command differs from stored last good word");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    bit_position >= POS_RESET && bit_position <= POS_SAT)
    else $error("bit position out of range");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(bit_position) && $stable(shift_word) && $stable(last_good))
    else $error("decoder state changed without an advancing request");

  a_block_only_on_emit: assert property (@(posedge clk) disable iff (rst)
    !edge_ready |-> s1_valid && emit && result_valid && !result_ready)
    else $error("edge channel stalled without a pending result");

endmodule
